### hw/rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// types and constants shared by the staging page allocator
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_SUBMIT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_FIT   = 3'd1;
    localparam logic [2:0] ST_Q_FULL   = 3'd2;
    localparam logic [2:0] ST_BAD_PAGE = 3'd3;
    localparam logic [2:0] ST_REF_OVF  = 3'd4;

    localparam logic [31:0] MIN_PAGE_RESET = 32'd4194304;
    localparam logic [15:0] REFS_MAX       = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] request_size;
        logic [4:0]  align_log2;
        logic [3:0]  page_slot;
        logic [47:0] completed_fence;
        logic [47:0] query_fence;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  granted_page;
        logic [31:0] granted_offset;
        logic        new_page;
        logic [31:0] new_page_size;
        logic [47:0] issued_fence;
        logic        upload_finished;
    } rsp_t;

endpackage

### hw/rtl/staging_page_allocator.sv
// ----------------------------------------------------------------------------
// staging_page_allocator
// best-fit bump allocator over staging pages with fence-deferred release
// ----------------------------------------------------------------------------
// channel   dir  handshake       payload
// req       in   valid / stall   spa_pkg::req_t
// rsp       out  valid / stall   spa_pkg::rsp_t
// cfg       in   valid / ready   min_page_size (32 bits)
//
// one request at a time: accept, a queue read then an apply per drained
// release, one queue read (plus an apply when the head is not yet due),
// dispatch, a scan over all MAX_PAGES slots and an allocate step for an
// allocate, then the response; submit, query and unused commands go from
// dispatch straight to the response
// the release queue is a one-port memory read one entry at a time
// reset clears page valid bits, counters and pointers at once, no sweep
// a stalled response holds in the output register; no new request meanwhile
module staging_page_allocator #(
    parameter int MAX_PAGES   = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  spa_pkg::req_t      req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output spa_pkg::rsp_t      rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = $clog2(MAX_PAGES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_QRD   = 7'b0000010,
        S_QAPP  = 7'b0000100,
        S_DISP  = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_ALLOC = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] min_page_reg;
    spa_pkg::req_t req_reg;
    spa_pkg::rsp_t rsp_reg;

    logic [MAX_PAGES-1:0] in_use_reg;
    logic [31:0] page_bytes [MAX_PAGES];
    logic [31:0] page_fill  [MAX_PAGES];
    logic [15:0] page_refs  [MAX_PAGES];

    logic [FW-1:0] next_free_reg;
    logic [47:0]   fence_reg;
    logic [QW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;

    // release queue: fence and page slot
    logic [47:0] q_fence [QUEUE_DEPTH];
    logic [PW-1:0] q_slot [QUEUE_DEPTH];
    logic [47:0]   qrd_fence_reg;
    logic [PW-1:0] qrd_slot_reg;

    // scan state
    logic [FW-1:0] scan_idx_reg;
    logic          found_reg;
    logic [PW-1:0] best_reg;
    logic [31:0]   best_rem_reg;
    logic [32:0]   need_reg;

    logic [PW-1:0] scan_p;
    logic [31:0]   scan_rem;
    logic          scan_hit;
    assign scan_p   = scan_idx_reg[PW-1:0];
    assign scan_rem = page_bytes[scan_p] - page_fill[scan_p];
    assign scan_hit = in_use_reg[scan_p] && ({1'b0, scan_rem} >= need_reg)
                      && (!found_reg || scan_rem < best_rem_reg);

    logic [31:0] align_mask;
    assign align_mask = (32'd1 << req_reg.align_log2) - 32'd1;

    logic [32:0] fresh_size;
    assign fresh_size = (need_reg > {1'b0, min_page_reg}) ? need_reg
                                                          : {1'b0, min_page_reg};

    // base fill of the chosen page, zero for a fresh one
    logic [31:0] base_fill;
    logic [32:0] aligned;
    assign base_fill = found_reg ? page_fill[best_reg] : 32'd0;
    assign aligned   = ({1'b0, base_fill} + {1'b0, align_mask})
                       & ~{1'b0, align_mask};

    logic slot_ok;
    assign slot_ok = ({1'b0, req_reg.page_slot} < 5'(MAX_PAGES))
                     && in_use_reg[req_reg.page_slot[PW-1:0]];

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_OUT);
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req_valid) state_next = S_QRD;
            S_QRD:   state_next = (count_reg != '0) ? S_QAPP : S_DISP;
            S_QAPP:  state_next = (qrd_fence_reg <= req_reg.completed_fence)
                                  ? S_QRD : S_DISP;
            S_DISP:  state_next = (req_reg.command == spa_pkg::CMD_ALLOC)
                                  ? S_SCAN : S_OUT;
            S_SCAN:  if (scan_idx_reg == FW'(MAX_PAGES - 1)) state_next = S_ALLOC;
            S_ALLOC: state_next = S_OUT;
            S_OUT:   if (!rsp_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            min_page_reg  <= spa_pkg::MIN_PAGE_RESET;
            in_use_reg    <= '0;
            next_free_reg <= '0;
            fence_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                min_page_reg <= cfg_data;
            case (state_reg)
                S_QAPP:
                    if (qrd_fence_reg <= req_reg.completed_fence)
                    begin
                        head_reg  <= (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                     : head_reg + QW'(1);
                        count_reg <= count_reg - CW'(1);
                    end
                S_DISP:
                    if (req_reg.command == spa_pkg::CMD_SUBMIT && slot_ok
                        && count_reg != CW'(QUEUE_DEPTH))
                    begin
                        fence_reg <= fence_reg + 48'd1;
                        tail_reg  <= (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                     : tail_reg + QW'(1);
                        count_reg <= count_reg + CW'(1);
                    end
                S_ALLOC:
                    if (!found_reg && next_free_reg < FW'(MAX_PAGES)
                        && !fresh_size[32])
                    begin
                        in_use_reg[next_free_reg[PW-1:0]] <= 1'b1;
                        next_free_reg <= next_free_reg + FW'(1);
                    end
                default: ;
            endcase
        end
    end

    // payload and memories
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (req_valid)
                begin
                    req_reg <= req;
                    need_reg <= {1'b0, req.request_size}
                                + ((33'd1 << req.align_log2) - 33'd1);
                end
            S_QRD:
            begin
                qrd_fence_reg <= q_fence[head_reg];
                qrd_slot_reg  <= q_slot[head_reg];
                scan_idx_reg  <= '0;
                found_reg     <= 1'b0;
            end
            S_QAPP:
                if (qrd_fence_reg <= req_reg.completed_fence
                    && in_use_reg[qrd_slot_reg] && page_refs[qrd_slot_reg] != '0)
                begin
                    page_refs[qrd_slot_reg] <= page_refs[qrd_slot_reg] - 16'd1;
                    if (page_refs[qrd_slot_reg] == 16'd1)
                        page_fill[qrd_slot_reg] <= '0;
                end
            S_DISP:
            begin
                rsp_reg.granted_page    <= '0;
                rsp_reg.granted_offset  <= '0;
                rsp_reg.new_page        <= 1'b0;
                rsp_reg.new_page_size   <= '0;
                rsp_reg.upload_finished <= (req_reg.command == spa_pkg::CMD_QUERY)
                    && (req_reg.query_fence <= req_reg.completed_fence);
                if (req_reg.command == spa_pkg::CMD_SUBMIT && !slot_ok)
                begin
                    rsp_reg.status       <= spa_pkg::ST_BAD_PAGE;
                    rsp_reg.issued_fence <= '0;
                end
                else if (req_reg.command == spa_pkg::CMD_SUBMIT
                         && count_reg == CW'(QUEUE_DEPTH))
                begin
                    rsp_reg.status       <= spa_pkg::ST_Q_FULL;
                    rsp_reg.issued_fence <= '0;
                end
                else if (req_reg.command == spa_pkg::CMD_SUBMIT)
                begin
                    rsp_reg.status       <= spa_pkg::ST_OK;
                    rsp_reg.issued_fence <= fence_reg + 48'd1;
                    q_fence[tail_reg]    <= fence_reg + 48'd1;
                    q_slot[tail_reg]     <= req_reg.page_slot[PW-1:0];
                end
                else
                begin
                    rsp_reg.status       <= spa_pkg::ST_OK;
                    rsp_reg.issued_fence <= '0;
                end
            end
            S_SCAN:
            begin
                scan_idx_reg <= scan_idx_reg + FW'(1);
                if (scan_hit)
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= scan_p;
                    best_rem_reg <= scan_rem;
                end
            end
            S_ALLOC:
            begin
                if (!found_reg && (next_free_reg >= FW'(MAX_PAGES) || fresh_size[32]))
                    rsp_reg.status <= spa_pkg::ST_NO_FIT;
                else if (found_reg && page_refs[best_reg] == spa_pkg::REFS_MAX)
                    rsp_reg.status <= spa_pkg::ST_REF_OVF;
                else if (found_reg)
                begin
                    page_fill[best_reg] <= aligned[31:0] + req_reg.request_size;
                    page_refs[best_reg] <= page_refs[best_reg] + 16'd1;
                    rsp_reg.granted_page   <= 4'(best_reg);
                    rsp_reg.granted_offset <= aligned[31:0];
                end
                else
                begin
                    page_bytes[next_free_reg[PW-1:0]] <= fresh_size[31:0];
                    page_fill[next_free_reg[PW-1:0]]  <= aligned[31:0]
                                                         + req_reg.request_size;
                    page_refs[next_free_reg[PW-1:0]]  <= 16'd1;
                    rsp_reg.granted_page   <= 4'(next_free_reg[PW-1:0]);
                    rsp_reg.granted_offset <= aligned[31:0];
                    rsp_reg.new_page       <= 1'b1;
                    rsp_reg.new_page_size  <= fresh_size[31:0];
                end
            end
            default: ;
        endcase
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= FW'(MAX_PAGES)) else $error("free slot overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response dropped under stall");

endmodule
